/* rtl/cpu8x_pkg.sv */
// Package for the 8-bit execute unit: item types, operation codes, flag positions.
package cpu8x_pkg;

    typedef struct packed {
        logic [6:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  data_third;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        last;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
        logic [15:0] pc_out;
    } t_out_item;

    // Architectural registers after one operation
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_regs;

    // Writes produced by one operation
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] addr0;
        logic [7:0]  data0;
        logic [15:0] addr1;
        logic [7:0]  data1;
        logic [15:0] addr2;
        logic [7:0]  data2;
    } t_writes;

    typedef enum logic [6:0] {
        OP_ADC = 7'd0, OP_AND = 7'd1, OP_ASL = 7'd2, OP_ASL_A = 7'd3, OP_BIT = 7'd4,
        OP_BRK = 7'd5, OP_BPL = 7'd6, OP_BMI = 7'd7, OP_BVC = 7'd8, OP_BVS = 7'd9,
        OP_BRA = 7'd10, OP_BCC = 7'd11, OP_BCS = 7'd12, OP_BNE = 7'd13,
        OP_BEQ = 7'd14, OP_CLC = 7'd15, OP_CLI = 7'd16, OP_CLV = 7'd17,
        OP_CLD = 7'd18, OP_CMP = 7'd19, OP_CPX = 7'd20, OP_CPY = 7'd21,
        OP_DEC = 7'd22, OP_DEC_A = 7'd23, OP_DEX = 7'd24, OP_DEY = 7'd25,
        OP_EOR = 7'd26, OP_INC = 7'd27, OP_INC_A = 7'd28, OP_INX = 7'd29,
        OP_INY = 7'd30, OP_JMP = 7'd31, OP_JMP_I = 7'd32, OP_JSR = 7'd33,
        OP_LDA = 7'd34, OP_LDX = 7'd35, OP_LDY = 7'd36, OP_LSR = 7'd37,
        OP_LSR_A = 7'd38, OP_ORA = 7'd39, OP_PHP = 7'd40, OP_PHA = 7'd41,
        OP_PHX = 7'd42, OP_PHY = 7'd43, OP_PLP = 7'd44, OP_PLA = 7'd45,
        OP_PLX = 7'd46, OP_PLY = 7'd47, OP_ROL = 7'd48, OP_ROL_A = 7'd49,
        OP_ROR = 7'd50, OP_ROR_A = 7'd51, OP_RTI = 7'd52, OP_RTS = 7'd53,
        OP_SBC = 7'd54, OP_SEC = 7'd55, OP_SED = 7'd56, OP_SEI = 7'd57,
        OP_STA = 7'd58, OP_STX = 7'd59, OP_STY = 7'd60, OP_STZ = 7'd61,
        OP_TRB = 7'd62, OP_TSB = 7'd63, OP_TXA = 7'd64, OP_TYA = 7'd65,
        OP_TXS = 7'd66, OP_TAY = 7'd67, OP_TAX = 7'd68, OP_TSX = 7'd69
    } t_op;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [7:0]  PUSH_P_MASK = 8'h30;

endpackage

/* rtl/cpu8x_alu.sv */
// Combinational execute logic: next register values and memory writes for one operation.
module cpu8x_alu (
    input  cpu8x_pkg::t_in_item i_item,
    input  cpu8x_pkg::t_regs    i_regs,
    output cpu8x_pkg::t_regs    o_regs,
    output cpu8x_pkg::t_writes  o_wr
);

    logic [7:0] d0, d1, d2;
    logic [7:0] a, x, y, sp, p;
    logic [15:0] pc, pc_m1, br_ext;
    logic       cin;
    logic [8:0] sum;
    logic [7:0] m;
    logic [7:0] t;
    logic [8:0] cmp_d;
    logic [7:0] cmp_r;

    assign d0  = i_item.data_first;
    assign d1  = i_item.data_second;
    assign d2  = i_item.data_third;
    assign a   = i_regs.a;
    assign x   = i_regs.x;
    assign y   = i_regs.y;
    assign sp  = i_regs.sp;
    assign p   = i_regs.p;
    assign pc  = i_regs.pc;
    assign cin = p[cpu8x_pkg::FLAG_C];
    assign pc_m1  = pc - 16'd1;
    assign br_ext = {{8{d0[7]}}, d0};

    // Shared adder for adc and sbc
    assign m   = (i_item.req_type == cpu8x_pkg::OP_SBC) ? ~d0 : d0;
    assign sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};

    // Shared compare subtractor
    always_comb begin
        case (i_item.req_type)
            cpu8x_pkg::OP_CPX: cmp_r = x;
            cpu8x_pkg::OP_CPY: cmp_r = y;
            default:           cmp_r = a;
        endcase
    end
    assign cmp_d = {1'b0, cmp_r} - {1'b0, d0};

    always_comb begin
        o_regs = i_regs;
        o_wr   = '0;
        t      = '0;
        case (i_item.req_type)
            cpu8x_pkg::OP_ADC, cpu8x_pkg::OP_SBC: begin
                o_regs.a = sum[7:0];
                o_regs.p[cpu8x_pkg::FLAG_C] = sum[8];
                o_regs.p[cpu8x_pkg::FLAG_V] = (a[7] ^ sum[7]) & (m[7] ^ sum[7]);
                t = sum[7:0];
            end
            cpu8x_pkg::OP_AND: begin o_regs.a = a & d0; t = a & d0; end
            cpu8x_pkg::OP_EOR: begin o_regs.a = a ^ d0; t = a ^ d0; end
            cpu8x_pkg::OP_ORA: begin o_regs.a = a | d0; t = a | d0; end
            cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_ROL: begin
                t = {d0[6:0], (i_item.req_type == cpu8x_pkg::OP_ROL) & cin};
                o_regs.p[cpu8x_pkg::FLAG_C] = d0[7];
                o_wr.count = 2'd1; o_wr.addr0 = i_item.addr; o_wr.data0 = t;
            end
            cpu8x_pkg::OP_ASL_A, cpu8x_pkg::OP_ROL_A: begin
                t = {a[6:0], (i_item.req_type == cpu8x_pkg::OP_ROL_A) & cin};
                o_regs.p[cpu8x_pkg::FLAG_C] = a[7];
                o_regs.a = t;
            end
            cpu8x_pkg::OP_LSR, cpu8x_pkg::OP_ROR: begin
                t = {(i_item.req_type == cpu8x_pkg::OP_ROR) & cin, d0[7:1]};
                o_regs.p[cpu8x_pkg::FLAG_C] = d0[0];
                o_wr.count = 2'd1; o_wr.addr0 = i_item.addr; o_wr.data0 = t;
            end
            cpu8x_pkg::OP_LSR_A, cpu8x_pkg::OP_ROR_A: begin
                t = {(i_item.req_type == cpu8x_pkg::OP_ROR_A) & cin, a[7:1]};
                o_regs.p[cpu8x_pkg::FLAG_C] = a[0];
                o_regs.a = t;
            end
            cpu8x_pkg::OP_BIT: begin
                o_regs.p[cpu8x_pkg::FLAG_N] = d0[7];
                o_regs.p[cpu8x_pkg::FLAG_V] = d0[6];
                o_regs.p[cpu8x_pkg::FLAG_Z] = (a & d0) == 8'd0;
            end
            cpu8x_pkg::OP_BRK: begin
                o_wr.count = 2'd3;
                o_wr.addr0 = {cpu8x_pkg::STACK_PAGE, sp};
                o_wr.data0 = pc[15:8];
                o_wr.addr1 = {cpu8x_pkg::STACK_PAGE, sp - 8'd1};
                o_wr.data1 = pc[7:0];
                o_wr.addr2 = {cpu8x_pkg::STACK_PAGE, sp - 8'd2};
                o_wr.data2 = p | cpu8x_pkg::PUSH_P_MASK;
                o_regs.sp = sp - 8'd3;
                o_regs.p[cpu8x_pkg::FLAG_I] = 1'b1;
                o_regs.pc = {d1, d0};
            end
            cpu8x_pkg::OP_BPL: if (!p[cpu8x_pkg::FLAG_N]) o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BMI: if (p[cpu8x_pkg::FLAG_N])  o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BVC: if (!p[cpu8x_pkg::FLAG_V]) o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BVS: if (p[cpu8x_pkg::FLAG_V])  o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BRA: o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BCC: if (!p[cpu8x_pkg::FLAG_C]) o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BCS: if (p[cpu8x_pkg::FLAG_C])  o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BNE: if (!p[cpu8x_pkg::FLAG_Z]) o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_BEQ: if (p[cpu8x_pkg::FLAG_Z])  o_regs.pc = pc + br_ext;
            cpu8x_pkg::OP_CLC: o_regs.p[cpu8x_pkg::FLAG_C] = 1'b0;
            cpu8x_pkg::OP_CLI: o_regs.p[cpu8x_pkg::FLAG_I] = 1'b0;
            cpu8x_pkg::OP_CLV: o_regs.p[cpu8x_pkg::FLAG_V] = 1'b0;
            cpu8x_pkg::OP_CLD: o_regs.p[cpu8x_pkg::FLAG_D] = 1'b0;
            cpu8x_pkg::OP_SEC: o_regs.p[cpu8x_pkg::FLAG_C] = 1'b1;
            cpu8x_pkg::OP_SED: o_regs.p[cpu8x_pkg::FLAG_D] = 1'b1;
            cpu8x_pkg::OP_SEI: o_regs.p[cpu8x_pkg::FLAG_I] = 1'b1;
            cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY: begin
                o_regs.p[cpu8x_pkg::FLAG_C] = ~cmp_d[8];
                t = cmp_d[7:0];
            end
            cpu8x_pkg::OP_DEC, cpu8x_pkg::OP_INC: begin
                t = (i_item.req_type == cpu8x_pkg::OP_INC) ? d0 + 8'd1 : d0 - 8'd1;
                o_wr.count = 2'd1; o_wr.addr0 = i_item.addr; o_wr.data0 = t;
            end
            cpu8x_pkg::OP_DEC_A: begin t = a - 8'd1; o_regs.a = t; end
            cpu8x_pkg::OP_INC_A: begin t = a + 8'd1; o_regs.a = t; end
            cpu8x_pkg::OP_DEX:   begin t = x - 8'd1; o_regs.x = t; end
            cpu8x_pkg::OP_INX:   begin t = x + 8'd1; o_regs.x = t; end
            cpu8x_pkg::OP_DEY:   begin t = y - 8'd1; o_regs.y = t; end
            cpu8x_pkg::OP_INY:   begin t = y + 8'd1; o_regs.y = t; end
            cpu8x_pkg::OP_JMP:   o_regs.pc = i_item.addr;
            cpu8x_pkg::OP_JMP_I: o_regs.pc = {d1, d0};
            cpu8x_pkg::OP_JSR: begin
                o_wr.count = 2'd2;
                o_wr.addr0 = {cpu8x_pkg::STACK_PAGE, sp};
                o_wr.data0 = pc_m1[15:8];
                o_wr.addr1 = {cpu8x_pkg::STACK_PAGE, sp - 8'd1};
                o_wr.data1 = pc_m1[7:0];
                o_regs.sp = sp - 8'd2;
                o_regs.pc = i_item.addr;
            end
            cpu8x_pkg::OP_LDA: begin o_regs.a = d0; t = d0; end
            cpu8x_pkg::OP_LDX: begin o_regs.x = d0; t = d0; end
            cpu8x_pkg::OP_LDY: begin o_regs.y = d0; t = d0; end
            cpu8x_pkg::OP_PHP, cpu8x_pkg::OP_PHA, cpu8x_pkg::OP_PHX,
            cpu8x_pkg::OP_PHY: begin
                o_wr.count = 2'd1;
                o_wr.addr0 = {cpu8x_pkg::STACK_PAGE, sp};
                case (i_item.req_type)
                    cpu8x_pkg::OP_PHP: o_wr.data0 = p | cpu8x_pkg::PUSH_P_MASK;
                    cpu8x_pkg::OP_PHX: o_wr.data0 = x;
                    cpu8x_pkg::OP_PHY: o_wr.data0 = y;
                    default:           o_wr.data0 = a;
                endcase
                o_regs.sp = sp - 8'd1;
            end
            cpu8x_pkg::OP_PLP: begin o_regs.sp = sp + 8'd1; o_regs.p = d0; end
            cpu8x_pkg::OP_PLA: begin o_regs.sp = sp + 8'd1; o_regs.a = d0; t = d0; end
            cpu8x_pkg::OP_PLX: begin o_regs.sp = sp + 8'd1; o_regs.x = d0; t = d0; end
            cpu8x_pkg::OP_PLY: begin o_regs.sp = sp + 8'd1; o_regs.y = d0; t = d0; end
            cpu8x_pkg::OP_RTI: begin
                o_regs.sp = sp + 8'd3;
                o_regs.p  = d0;
                o_regs.pc = {d2, d1};
            end
            cpu8x_pkg::OP_RTS: begin
                o_regs.sp = sp + 8'd2;
                o_regs.pc = {d1, d0} + 16'd1;
            end
            cpu8x_pkg::OP_STA, cpu8x_pkg::OP_STX, cpu8x_pkg::OP_STY,
            cpu8x_pkg::OP_STZ: begin
                o_wr.count = 2'd1;
                o_wr.addr0 = i_item.addr;
                case (i_item.req_type)
                    cpu8x_pkg::OP_STA: o_wr.data0 = a;
                    cpu8x_pkg::OP_STX: o_wr.data0 = x;
                    cpu8x_pkg::OP_STY: o_wr.data0 = y;
                    default:           o_wr.data0 = 8'd0;
                endcase
            end
            cpu8x_pkg::OP_TRB, cpu8x_pkg::OP_TSB: begin
                o_regs.p[cpu8x_pkg::FLAG_Z] = (a & d0) == 8'd0;
                o_wr.count = 2'd1;
                o_wr.addr0 = i_item.addr;
                o_wr.data0 = (i_item.req_type == cpu8x_pkg::OP_TRB) ? (d0 & ~a) : (d0 | a);
            end
            cpu8x_pkg::OP_TXA: begin o_regs.a = x; t = x; end
            cpu8x_pkg::OP_TYA: begin o_regs.a = y; t = y; end
            cpu8x_pkg::OP_TXS: o_regs.sp = x;
            cpu8x_pkg::OP_TAY: begin o_regs.y = a; t = a; end
            cpu8x_pkg::OP_TAX: begin o_regs.x = a; t = a; end
            cpu8x_pkg::OP_TSX: begin o_regs.x = sp; t = sp; end
            default: ;
        endcase

        // Set N and Z from the result value where the operation does
        case (i_item.req_type)
            cpu8x_pkg::OP_ADC, cpu8x_pkg::OP_SBC, cpu8x_pkg::OP_AND, cpu8x_pkg::OP_EOR,
            cpu8x_pkg::OP_ORA, cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_ROL, cpu8x_pkg::OP_ASL_A,
            cpu8x_pkg::OP_ROL_A, cpu8x_pkg::OP_LSR, cpu8x_pkg::OP_ROR, cpu8x_pkg::OP_LSR_A,
            cpu8x_pkg::OP_ROR_A, cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY,
            cpu8x_pkg::OP_DEC, cpu8x_pkg::OP_INC, cpu8x_pkg::OP_DEC_A, cpu8x_pkg::OP_INC_A,
            cpu8x_pkg::OP_DEX, cpu8x_pkg::OP_INX, cpu8x_pkg::OP_DEY, cpu8x_pkg::OP_INY,
            cpu8x_pkg::OP_LDA, cpu8x_pkg::OP_LDX, cpu8x_pkg::OP_LDY, cpu8x_pkg::OP_PLA,
            cpu8x_pkg::OP_PLX, cpu8x_pkg::OP_PLY, cpu8x_pkg::OP_TXA, cpu8x_pkg::OP_TYA,
            cpu8x_pkg::OP_TAY, cpu8x_pkg::OP_TAX, cpu8x_pkg::OP_TSX: begin
                o_regs.p[cpu8x_pkg::FLAG_N] = t[7];
                o_regs.p[cpu8x_pkg::FLAG_Z] = (t == 8'd0);
            end
            default: ;
        endcase
    end

endmodule

/* rtl/eight_bit_cpu_execute_unit.sv */
// Top level of the 8-bit execute unit: register file, result queue and handshakes.
//
// At most one instruction item is executed per cycle: the execute logic is a single
// combinational pass from the architectural registers and the item to the next
// register values, which are committed at acceptance. Each item yields one result
// item per memory write (up to three, for BRK) or a single result with no write;
// the results sit in a three-entry queue behind the execute logic. Items that write
// at most once sustain one item per cycle unless the receiver stalls; an item with
// several writes keeps the input stalled while its extra results drain, one per
// cycle unless stalled. The first result appears the cycle after acceptance.
module eight_bit_cpu_execute_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  cpu8x_pkg::t_in_item   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output cpu8x_pkg::t_out_item  o_item
);

    cpu8x_pkg::t_regs   r_regs, n_regs;
    cpu8x_pkg::t_writes wr;
    cpu8x_pkg::t_out_item r_q [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] add_cnt;
    logic       acc_in, pop;

    cpu8x_alu u_alu (
        .i_item (i_item),
        .i_regs (r_regs),
        .o_regs (n_regs),
        .o_wr   (wr)
    );

    // Take a new item only when the queue has nothing waiting beyond what leaves now
    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_cnt > 2'd1) || (r_cnt == 2'd1 && i_stall);
    assign acc_in  = i_valid && !o_stall;
    assign add_cnt = (wr.count == 2'd0) ? 2'd1 : wr.count;
    assign n_cnt   = r_cnt - {1'b0, pop} + (acc_in ? add_cnt : 2'd0);

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[0];

    // Commit registers on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
            r_cnt  <= '0;
        end else begin
            if (acc_in) r_regs <= n_regs;
            r_cnt <= n_cnt;
        end
    end

    // Load or advance the result queue
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k].acc_out    <= n_regs.a;
                r_q[k].x_out      <= n_regs.x;
                r_q[k].y_out      <= n_regs.y;
                r_q[k].sp_out     <= n_regs.sp;
                r_q[k].status_out <= n_regs.p;
                r_q[k].pc_out     <= n_regs.pc;
                r_q[k].last       <= (k == 32'(add_cnt) - 1);
                r_q[k].write_valid <= (k < 32'(wr.count));
            end
            r_q[0].write_addr <= wr.addr0;
            r_q[0].write_data <= wr.data0;
            r_q[1].write_addr <= wr.addr1;
            r_q[1].write_data <= wr.data1;
            r_q[2].write_addr <= wr.addr2;
            r_q[2].write_data <= wr.data2;
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 || !o_valid) else $error("queue count and valid disagree");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("item accepted over pending results");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cnt == 2'd1) |-> o_item.last)
        else $error("final queued result not marked last");
    a_regs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc_in |=> $stable(r_regs)) else $error("registers changed without item");

endmodule

/* bench/eight_bit_cpu_execute_unit_checker.sv */
// Checker for the 8-bit execute unit: predicts results of accepted items and compares.
`timescale 1ns / 1ps

module eight_bit_cpu_execute_unit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall_in,
    input  cpu8x_pkg::t_in_item  i_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  cpu8x_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);

    // Architectural copy of the block
    logic [7:0]  acc, rx, ry, rsp, rp;
    logic [15:0] rpc;
    cpu8x_pkg::t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic [7:0] nz_flags(logic [7:0] p, logic [7:0] v);
        p[cpu8x_pkg::FLAG_N] = v[7];
        p[cpu8x_pkg::FLAG_Z] = (v == 8'd0);
        return p;
    endfunction

    // Execute one item on the copy and queue its results
    task automatic execute_item(cpu8x_pkg::t_in_item it);
        logic [15:0] wa[3];
        logic [7:0]  wd[3];
        int          nw;
        int          n;
        logic [8:0]  sum;
        logic [7:0]  m, t, vx;
        logic        cin;
        logic        take;
        cpu8x_pkg::t_out_item r;
        nw = 0;
        cin = rp[cpu8x_pkg::FLAG_C];
        take = 1'b0;
        case (it.req_type)
            cpu8x_pkg::OP_ADC, cpu8x_pkg::OP_SBC: begin
                m = (it.req_type == cpu8x_pkg::OP_SBC) ? ~it.data_first : it.data_first;
                sum = {1'b0, acc} + {1'b0, m} + {8'd0, cin};
                rp[cpu8x_pkg::FLAG_C] = sum[8];
                vx = (acc ^ sum[7:0]) & (m ^ sum[7:0]);
                rp[cpu8x_pkg::FLAG_V] = vx[7];
                acc = sum[7:0];
                rp = nz_flags(rp, acc);
            end
            cpu8x_pkg::OP_AND: begin acc = acc & it.data_first; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_EOR: begin acc = acc ^ it.data_first; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_ORA: begin acc = acc | it.data_first; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_ROL: begin
                t = {it.data_first[6:0], (it.req_type == cpu8x_pkg::OP_ROL) ? cin : 1'b0};
                rp[cpu8x_pkg::FLAG_C] = it.data_first[7];
                rp = nz_flags(rp, t);
                wa[nw] = it.addr; wd[nw] = t; nw++;
            end
            cpu8x_pkg::OP_ASL_A, cpu8x_pkg::OP_ROL_A: begin
                rp[cpu8x_pkg::FLAG_C] = acc[7];
                acc = {acc[6:0], (it.req_type == cpu8x_pkg::OP_ROL_A) ? cin : 1'b0};
                rp = nz_flags(rp, acc);
            end
            cpu8x_pkg::OP_LSR, cpu8x_pkg::OP_ROR: begin
                t = {(it.req_type == cpu8x_pkg::OP_ROR) ? cin : 1'b0, it.data_first[7:1]};
                rp[cpu8x_pkg::FLAG_C] = it.data_first[0];
                rp = nz_flags(rp, t);
                wa[nw] = it.addr; wd[nw] = t; nw++;
            end
            cpu8x_pkg::OP_LSR_A, cpu8x_pkg::OP_ROR_A: begin
                rp[cpu8x_pkg::FLAG_C] = acc[0];
                acc = {(it.req_type == cpu8x_pkg::OP_ROR_A) ? cin : 1'b0, acc[7:1]};
                rp = nz_flags(rp, acc);
            end
            cpu8x_pkg::OP_BIT: begin
                rp[cpu8x_pkg::FLAG_N] = it.data_first[7];
                rp[cpu8x_pkg::FLAG_V] = it.data_first[6];
                rp[cpu8x_pkg::FLAG_Z] = ((acc & it.data_first) == 8'd0);
            end
            cpu8x_pkg::OP_BRK: begin
                wa[0] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[0] = rpc[15:8]; rsp--;
                wa[1] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[1] = rpc[7:0]; rsp--;
                wa[2] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[2] = rp | cpu8x_pkg::PUSH_P_MASK;
                rsp--;
                nw = 3;
                rp[cpu8x_pkg::FLAG_I] = 1'b1;
                rpc = {it.data_second, it.data_first};
            end
            cpu8x_pkg::OP_BPL: take = !rp[cpu8x_pkg::FLAG_N];
            cpu8x_pkg::OP_BMI: take = rp[cpu8x_pkg::FLAG_N];
            cpu8x_pkg::OP_BVC: take = !rp[cpu8x_pkg::FLAG_V];
            cpu8x_pkg::OP_BVS: take = rp[cpu8x_pkg::FLAG_V];
            cpu8x_pkg::OP_BRA: take = 1'b1;
            cpu8x_pkg::OP_BCC: take = !rp[cpu8x_pkg::FLAG_C];
            cpu8x_pkg::OP_BCS: take = rp[cpu8x_pkg::FLAG_C];
            cpu8x_pkg::OP_BNE: take = !rp[cpu8x_pkg::FLAG_Z];
            cpu8x_pkg::OP_BEQ: take = rp[cpu8x_pkg::FLAG_Z];
            cpu8x_pkg::OP_CLC: rp[cpu8x_pkg::FLAG_C] = 1'b0;
            cpu8x_pkg::OP_CLI: rp[cpu8x_pkg::FLAG_I] = 1'b0;
            cpu8x_pkg::OP_CLV: rp[cpu8x_pkg::FLAG_V] = 1'b0;
            cpu8x_pkg::OP_CLD: rp[cpu8x_pkg::FLAG_D] = 1'b0;
            cpu8x_pkg::OP_SEC: rp[cpu8x_pkg::FLAG_C] = 1'b1;
            cpu8x_pkg::OP_SED: rp[cpu8x_pkg::FLAG_D] = 1'b1;
            cpu8x_pkg::OP_SEI: rp[cpu8x_pkg::FLAG_I] = 1'b1;
            cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY: begin
                m = (it.req_type == cpu8x_pkg::OP_CMP) ? acc :
                    (it.req_type == cpu8x_pkg::OP_CPX) ? rx : ry;
                rp[cpu8x_pkg::FLAG_C] = (m >= it.data_first);
                rp = nz_flags(rp, m - it.data_first);
            end
            cpu8x_pkg::OP_DEC, cpu8x_pkg::OP_INC: begin
                t = (it.req_type == cpu8x_pkg::OP_DEC) ? it.data_first - 8'd1
                                                       : it.data_first + 8'd1;
                rp = nz_flags(rp, t);
                wa[nw] = it.addr; wd[nw] = t; nw++;
            end
            cpu8x_pkg::OP_DEC_A: begin acc--; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_INC_A: begin acc++; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_DEX: begin rx--; rp = nz_flags(rp, rx); end
            cpu8x_pkg::OP_INX: begin rx++; rp = nz_flags(rp, rx); end
            cpu8x_pkg::OP_DEY: begin ry--; rp = nz_flags(rp, ry); end
            cpu8x_pkg::OP_INY: begin ry++; rp = nz_flags(rp, ry); end
            cpu8x_pkg::OP_JMP: rpc = it.addr;
            cpu8x_pkg::OP_JMP_I: rpc = {it.data_second, it.data_first};
            cpu8x_pkg::OP_JSR: begin
                rpc--;
                wa[0] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[0] = rpc[15:8]; rsp--;
                wa[1] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[1] = rpc[7:0]; rsp--;
                nw = 2;
                rpc = it.addr;
            end
            cpu8x_pkg::OP_LDA: begin acc = it.data_first; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_LDX: begin rx = it.data_first; rp = nz_flags(rp, rx); end
            cpu8x_pkg::OP_LDY: begin ry = it.data_first; rp = nz_flags(rp, ry); end
            cpu8x_pkg::OP_PHP, cpu8x_pkg::OP_PHA, cpu8x_pkg::OP_PHX, cpu8x_pkg::OP_PHY: begin
                case (it.req_type)
                    cpu8x_pkg::OP_PHP: t = rp | cpu8x_pkg::PUSH_P_MASK;
                    cpu8x_pkg::OP_PHA: t = acc;
                    cpu8x_pkg::OP_PHX: t = rx;
                    default:           t = ry;
                endcase
                wa[0] = {cpu8x_pkg::STACK_PAGE, rsp}; wd[0] = t; rsp--; nw = 1;
            end
            cpu8x_pkg::OP_PLP: begin rsp++; rp = it.data_first; end
            cpu8x_pkg::OP_PLA: begin rsp++; acc = it.data_first; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_PLX: begin rsp++; rx = it.data_first; rp = nz_flags(rp, rx); end
            cpu8x_pkg::OP_PLY: begin rsp++; ry = it.data_first; rp = nz_flags(rp, ry); end
            cpu8x_pkg::OP_RTI: begin
                rsp = rsp + 8'd3;
                rp = it.data_first;
                rpc = {it.data_third, it.data_second};
            end
            cpu8x_pkg::OP_RTS: begin
                rsp = rsp + 8'd2;
                rpc = {it.data_second, it.data_first} + 16'd1;
            end
            cpu8x_pkg::OP_STA: begin wa[0] = it.addr; wd[0] = acc; nw = 1; end
            cpu8x_pkg::OP_STX: begin wa[0] = it.addr; wd[0] = rx; nw = 1; end
            cpu8x_pkg::OP_STY: begin wa[0] = it.addr; wd[0] = ry; nw = 1; end
            cpu8x_pkg::OP_STZ: begin wa[0] = it.addr; wd[0] = 8'd0; nw = 1; end
            cpu8x_pkg::OP_TRB, cpu8x_pkg::OP_TSB: begin
                rp[cpu8x_pkg::FLAG_Z] = ((it.data_first & acc) == 8'd0);
                wa[0] = it.addr;
                wd[0] = (it.req_type == cpu8x_pkg::OP_TRB) ? it.data_first & ~acc
                                                           : it.data_first | acc;
                nw = 1;
            end
            cpu8x_pkg::OP_TXA: begin acc = rx; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_TYA: begin acc = ry; rp = nz_flags(rp, acc); end
            cpu8x_pkg::OP_TXS: rsp = rx;
            cpu8x_pkg::OP_TAY: begin ry = acc; rp = nz_flags(rp, ry); end
            cpu8x_pkg::OP_TAX: begin rx = acc; rp = nz_flags(rp, rx); end
            cpu8x_pkg::OP_TSX: begin rx = rsp; rp = nz_flags(rp, rx); end
            default: ;
        endcase
        if (take) begin
            rpc = rpc + {{8{it.data_first[7]}}, it.data_first};
        end
        n = (nw > 0) ? nw : 1;
        for (int k = 0; k < n; k++) begin
            r.write_valid = (k < nw);
            r.write_addr  = (k < nw) ? wa[k] : 16'd0;
            r.write_data  = (k < nw) ? wd[k] : 8'd0;
            r.last        = (k == n - 1);
            r.acc_out     = acc;
            r.x_out       = rx;
            r.y_out       = ry;
            r.sp_out      = rsp;
            r.status_out  = rp;
            r.pc_out      = rpc;
            expected_results.push_back(r);
        end
    endtask

    // Watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc <= 8'd0; rx <= 8'd0; ry <= 8'd0; rsp <= 8'd0; rp <= 8'd0; rpc <= 16'd0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (expected_results[0] !== i_out_item) begin
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 expected_results[0], i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (i_valid && !i_stall_in) begin
                execute_item(i_item);
            end
        end
    end

    initial o_fail_count = 0;

endmodule

/* bench/eight_bit_cpu_execute_unit_tb.sv */
// Testbench top for the 8-bit execute unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module eight_bit_cpu_execute_unit_tb;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    cpu8x_pkg::t_in_item  i_item;
    logic                 o_valid;
    logic                 i_stall;
    cpu8x_pkg::t_out_item o_item;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    eight_bit_cpu_execute_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    eight_bit_cpu_execute_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_item       (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stalls at random, at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one item, idling first as the sender's rate says; valid stays up after it
    task automatic send_instr(cpu8x_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cpu8x_pkg::t_in_item make_instr(logic [6:0] op, logic [15:0] a,
                                                       logic [7:0] d0, logic [7:0] d1,
                                                       logic [7:0] d2);
        cpu8x_pkg::t_in_item it;
        it.req_type = op; it.addr = a;
        it.data_first = d0; it.data_second = d1; it.data_third = d2;
        return it;
    endfunction

    function automatic cpu8x_pkg::t_in_item rand_instr();
        logic [6:0] op;
        op = ($urandom_range(19) == 0) ? 7'($urandom_range(127, 70))
                                       : 7'($urandom_range(69));
        return make_instr(op, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item  = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, carries, overflow, wraps, stack and branches
        send_instr(make_instr(cpu8x_pkg::OP_LDA, 16'hFFFF, 8'h7F, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_ADC, 16'h0000, 8'h01, 8'hFF, 8'hFF));
        send_instr(make_instr(cpu8x_pkg::OP_SBC, 16'h0000, 8'hFF, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_CMP, 16'h0000, 8'h80, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_BRK, 16'hFFFF, 8'hFE, 8'hFF, 8'hFF));
        send_instr(make_instr(cpu8x_pkg::OP_RTI, 16'h0000, 8'hFF, 8'h34, 8'h12));
        send_instr(make_instr(cpu8x_pkg::OP_JSR, 16'h8000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_RTS, 16'h0000, 8'hFF, 8'hFF, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_BRA, 16'h0000, 8'h80, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_BNE, 16'h0000, 8'h7F, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_PLX, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_PHX, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_TXS, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_ASL_A, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_SED, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_ADC, 16'h0000, 8'h09, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_BIT, 16'h0000, 8'hC0, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_TRB, 16'h1234, 8'hFF, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_TSB, 16'h1234, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_ROR, 16'hFFFF, 8'h01, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_PLP, 16'h0000, 8'hFF, 8'h00, 8'h00));
        send_instr(make_instr(cpu8x_pkg::OP_PHP, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_instr(make_instr(7'd127, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));

        // Hold off until the block has drained
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // Random, in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 23 : 0;
            for (int i = 0; i < 36; i++) begin
                send_instr(rand_instr());
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
